// ===== rtl/region_pair_edge_aggregator_assert.svh =====
// Assertion macros used by the top level of the region pair edge aggregator.
`ifndef REGION_PAIR_EDGE_AGGREGATOR_ASSERT_SVH
`define REGION_PAIR_EDGE_AGGREGATOR_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define RPEA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpea assertion failed");

// Next-cycle implication, held off during reset.
`define RPEA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpea assertion failed");

`endif

// ===== rtl/rpea_pkg.sv =====
// Package: constants, types and helpers of the region pair edge aggregator.
package rpea_pkg;

  localparam int REGIONS     = 16;
  localparam int WEIGHT_BITS = 32;

  localparam int PAIRS  = (REGIONS * (REGIONS - 1)) / 2;
  localparam int IDX_W  = $clog2(PAIRS);
  localparam int W_EFF  = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
  localparam logic [31:0] W_MASK = 32'((64'd1 << W_EFF) - 64'd1);
  localparam logic [47:0] MAX48  = '1;
  localparam logic [31:0] MAX32  = '1;
  localparam logic [6:0]  MAX7   = '1;

  typedef enum logic [1:0] {
    MODE_EDGE  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_SAME       = 2'd0,
    KIND_UNASSIGNED = 2'd1,
    KIND_NEW        = 2'd2,
    KIND_EXISTING   = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [31:0] count;
    logic [47:0] sum;
    logic [31:0] min;
    logic [31:0] max;
  } entry_t;

  typedef struct packed {
    logic cap;     // take the input beat and start the table read
    logic commit;  // write back and load the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic       out_valid;
    logic [1:0] mode;
  } dp_status_t;

  typedef struct packed {
    logic [1:0]  edge_kind;
    logic        pair_present;
    entry_t      pair;
    logic [31:0] unassigned;
    logic [6:0]  connected;
    logic [31:0] border;
  } result_t;

  function automatic logic region_ok(input logic [4:0] r);
    return !r[4] && ({27'b0, r} < 32'(REGIONS));
  endfunction

  // Triangular index of the unordered pair (a < b).
  function automatic logic [IDX_W-1:0] pair_index(input logic [4:0] r1, input logic [4:0] r2);
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] t;
    a = (r1 < r2) ? {11'b0, r1} : {11'b0, r2};
    b = (r1 < r2) ? {11'b0, r2} : {11'b0, r1};
    t = a * 16'(2 * REGIONS - 1) - a * a;
    return IDX_W'((t >> 1) + b - a - 16'd1);
  endfunction

endpackage

// ===== rtl/rpea_ctrl.sv =====
// Controller: sequences capture, table read and write-back of each beat.
module rpea_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  input  logic                   m_ready_i,
  input  rpea_pkg::dp_status_t   status_i,
  output logic                   s_ready_o,
  output rpea_pkg::ctrl_cmd_t    cmd_o
);

  rpea_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpea_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    s_ready_o   = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      rpea_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = rpea_pkg::ST_EXEC;
        end
      end
      rpea_pkg::ST_EXEC: begin
        // wait here while an earlier result is still unclaimed
        if (!status_i.out_valid || m_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = rpea_pkg::ST_IDLE;
        end
      end
      default: state_d = rpea_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/rpea_datapath.sv =====
// Datapath: pair table, valid marks, totals and the output register.
module rpea_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            mode_i,
  input  logic [4:0]            source_region_i,
  input  logic [4:0]            target_region_i,
  input  logic [31:0]           weight_i,
  input  rpea_pkg::ctrl_cmd_t   cmd_i,
  input  logic                  m_ready_i,
  output rpea_pkg::dp_status_t  status_o,
  output rpea_pkg::result_t     result_o
);

  localparam int IW = rpea_pkg::IDX_W;

  rpea_pkg::entry_t mem [rpea_pkg::PAIRS];
  rpea_pkg::entry_t rd_q;

  logic [rpea_pkg::PAIRS-1:0] valid_q;
  logic [31:0] unassigned_q, unassigned_d;
  logic [6:0]  connected_q, connected_d;
  logic [31:0] border_q, border_d;

  logic [1:0]    mode_q;
  logic          same_q;
  logic          have_q;
  logic [IW-1:0] idx_q;
  logic [31:0]   w_q;

  logic          have_d;
  logic [IW-1:0] idx_d;

  logic              ent_valid;
  logic              wr_en;
  logic              clr;
  logic [48:0]       sum_ext;
  rpea_pkg::entry_t  upd;
  rpea_pkg::result_t res_d;
  rpea_pkg::result_t res_q;
  logic              out_valid_q;

  assign have_d = rpea_pkg::region_ok(source_region_i) &&
                  rpea_pkg::region_ok(target_region_i) &&
                  (source_region_i != target_region_i);
  assign idx_d  = rpea_pkg::pair_index(source_region_i, target_region_i);

  // capture registers and the registered table read
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      mode_q <= mode_i;
      same_q <= (source_region_i == target_region_i);
      have_q <= have_d;
      idx_q  <= idx_d;
      w_q    <= weight_i & rpea_pkg::W_MASK;
      rd_q   <= mem[idx_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx_q] <= upd;
    end
  end

  assign ent_valid = valid_q[idx_q];
  assign sum_ext   = {1'b0, rd_q.sum} + {17'b0, w_q};

  always_comb begin
    if (!ent_valid) begin
      upd.count = 32'd1;
      upd.sum   = {16'b0, w_q};
      upd.min   = w_q;
      upd.max   = w_q;
    end else begin
      upd.count = (rd_q.count == rpea_pkg::MAX32) ? rd_q.count : rd_q.count + 32'd1;
      upd.sum   = sum_ext[48] ? rpea_pkg::MAX48 : sum_ext[47:0];
      upd.min   = (w_q < rd_q.min) ? w_q : rd_q.min;
      upd.max   = (w_q > rd_q.max) ? w_q : rd_q.max;
    end
  end

  always_comb begin
    unassigned_d = unassigned_q;
    connected_d  = connected_q;
    border_d     = border_q;
    wr_en        = 1'b0;
    clr          = 1'b0;
    res_d        = '0;
    unique case (mode_q)
      rpea_pkg::MODE_EDGE: begin
        priority if (same_q) begin
          res_d.edge_kind = rpea_pkg::KIND_SAME;
        end else if (!have_q) begin
          if (unassigned_q != rpea_pkg::MAX32) unassigned_d = unassigned_q + 32'd1;
          res_d.edge_kind = rpea_pkg::KIND_UNASSIGNED;
        end else begin
          wr_en = cmd_i.commit;
          if (!ent_valid && connected_q != rpea_pkg::MAX7) connected_d = connected_q + 7'd1;
          if (border_q != rpea_pkg::MAX32) border_d = border_q + 32'd1;
          res_d.edge_kind    = ent_valid ? rpea_pkg::KIND_EXISTING : rpea_pkg::KIND_NEW;
          res_d.pair_present = 1'b1;
          res_d.pair         = upd;
        end
      end
      rpea_pkg::MODE_QUERY: begin
        if (have_q && ent_valid) begin
          res_d.pair_present = 1'b1;
          res_d.pair         = rd_q;
        end
      end
      rpea_pkg::MODE_CLEAR: begin
        clr          = 1'b1;
        unassigned_d = '0;
        connected_d  = '0;
        border_d     = '0;
      end
      default: ;
    endcase
    res_d.unassigned = unassigned_d;
    res_d.connected  = connected_d;
    res_d.border     = border_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      unassigned_q <= '0;
      connected_q  <= '0;
      border_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        unassigned_q <= unassigned_d;
        connected_q  <= connected_d;
        border_q     <= border_d;
        if (clr) begin
          valid_q <= '0;
        end else if (wr_en) begin
          valid_q[idx_q] <= 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  assign status_o.out_valid = out_valid_q;
  assign status_o.mode      = mode_q;
  assign result_o           = res_q;

endmodule

// ===== rtl/region_pair_edge_aggregator.sv =====
// Result beat: each accepted beat is captured with its table read, then written back and loaded
//   into the output register in ST_EXEC once the output is free.
// Beats are taken one at a time: the pair table is read at capture and written back at commit.
// A new input beat is taken while the previous result waits in the output register.
// Reset clears valid marks and totals at once; there is no clearing pass.
// Top level: stream ports, controller and datapath of the region pair edge aggregator.
module region_pair_edge_aggregator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // source_region[4:0], target_region[9:5], weight[41:10]
  input  logic [1:0]   s_axis_tuser,  // mode[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pair_present[0], pair_edge_count[32:1], pair_total_weight[80:33],
  // pair_min_weight[112:81], pair_max_weight[144:113],
  // unassigned_edge_count[176:145], connected_pair_count[183:177],
  // border_edge_count[215:184]
  output logic [215:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser   // edge_kind[1:0]
);

  rpea_pkg::ctrl_cmd_t  cmd;
  rpea_pkg::dp_status_t status;
  rpea_pkg::result_t    res;

  rpea_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  rpea_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (s_axis_tuser),
    .source_region_i (s_axis_tdata[4:0]),
    .target_region_i (s_axis_tdata[9:5]),
    .weight_i        (s_axis_tdata[41:10]),
    .cmd_i           (cmd),
    .m_ready_i       (m_axis_tready),
    .status_o        (status),
    .result_o        (res)
  );

  assign m_axis_tvalid = status.out_valid;
  assign m_axis_tuser  = res.edge_kind;
  assign m_axis_tdata  = {res.border, res.connected, res.unassigned, res.pair.max,
                          res.pair.min, res.pair.sum, res.pair.count, res.pair_present};

`include "region_pair_edge_aggregator_assert.svh"

  // one beat in flight: no second capture straight after the first
  `RPEA_ASSERT_NXT(a_busy_after_cap, cmd.cap, !s_axis_tready)
  // a waiting result is never overwritten
  `RPEA_ASSERT_IMP(a_no_overwrite, cmd.commit, !m_axis_tvalid || m_axis_tready)
  // a clear leaves every total at zero in its result
  `RPEA_ASSERT_NXT(a_clear_zero, cmd.commit && status.mode == rpea_pkg::MODE_CLEAR,
                   m_axis_tdata == '0 && m_axis_tuser == '0)
  // capture and write-back never coincide
  `RPEA_ASSERT_IMP(a_cap_commit_excl, cmd.cap, !cmd.commit)

endmodule

// ===== test/region_pair_edge_aggregator_test.sv =====
// Stream testbench of the region pair edge aggregator with a pair statistics scoreboard.
module region_pair_edge_aggregator_test;
  import rpea_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;  // undefined mode, must change nothing
  localparam int CLK_HALF = 10;
  localparam int RUN_LIMIT = 4_000_000;
  localparam int RANDOM_BEATS = 1250;

  typedef struct {
    kind_e       edge_kind;
    logic        present;
    logic [31:0] count;
    logic [47:0] sum;
    logic [31:0] min_w;
    logic [31:0] max_w;
    logic [31:0] unassigned;
    logic [6:0]  connected;
    logic [31:0] border;
  } pair_report_t;

  class region_pair_tracker;
    bit          pair_valid [REGIONS][REGIONS];
    logic [31:0] pair_count [REGIONS][REGIONS];
    logic [47:0] pair_sum [REGIONS][REGIONS];
    logic [31:0] pair_min [REGIONS][REGIONS];
    logic [31:0] pair_max [REGIONS][REGIONS];
    logic [31:0] unassigned_total;
    logic [6:0]  connected_total;
    logic [31:0] border_total;
    pair_report_t expected_results[$];
    int fails;
    int n_edges;
    int n_queries;
    int n_clears;
    int n_checked;

    function new();
      fails = 0;
      n_edges = 0;
      n_queries = 0;
      n_clears = 0;
      n_checked = 0;
      unassigned_total = '0;
      connected_total = '0;
      border_total = '0;
      foreach (pair_valid[i, j]) pair_valid[i][j] = 1'b0;
    endfunction

    function automatic bit assigned(int r);
      return r >= 0 && r < REGIONS;
    endfunction

    // Work out the report of one input beat and advance the tracked state.
    function void note_beat(logic [1:0] mode, logic [4:0] src, logic [4:0] tgt,
                            logic [31:0] w);
      pair_report_t r;
      int s;
      int t;
      int lo;
      int hi;
      bit addressed;
      logic [48:0] acc;
      s = $signed(src);
      t = $signed(tgt);
      lo = (s < t) ? s : t;
      hi = (s < t) ? t : s;
      addressed = 1'b0;
      r = '{edge_kind: KIND_SAME, default: '0};
      case (mode)
        MODE_EDGE: begin
          n_edges++;
          if (s == t) begin
            r.edge_kind = KIND_SAME;
          end else if (!assigned(s) || !assigned(t)) begin
            if (unassigned_total != MAX32) unassigned_total++;
            r.edge_kind = KIND_UNASSIGNED;
          end else begin
            addressed = 1'b1;
            if (!pair_valid[lo][hi]) begin
              pair_valid[lo][hi] = 1'b1;
              pair_count[lo][hi] = 32'd1;
              pair_sum[lo][hi] = {16'b0, w};
              pair_min[lo][hi] = w;
              pair_max[lo][hi] = w;
              if (connected_total != MAX7) connected_total++;
              r.edge_kind = KIND_NEW;
            end else begin
              if (pair_count[lo][hi] != MAX32) pair_count[lo][hi]++;
              acc = {1'b0, pair_sum[lo][hi]} + {17'b0, w};
              pair_sum[lo][hi] = acc[48] ? MAX48 : acc[47:0];
              if (w < pair_min[lo][hi]) pair_min[lo][hi] = w;
              if (w > pair_max[lo][hi]) pair_max[lo][hi] = w;
              r.edge_kind = KIND_EXISTING;
            end
            if (border_total != MAX32) border_total++;
          end
        end
        MODE_QUERY: begin
          n_queries++;
          addressed = s != t && assigned(s) && assigned(t);
        end
        MODE_CLEAR: begin
          n_clears++;
          foreach (pair_valid[i, j]) pair_valid[i][j] = 1'b0;
          unassigned_total = '0;
          connected_total = '0;
          border_total = '0;
        end
        default: ;
      endcase
      if (addressed && pair_valid[lo][hi]) begin
        r.present = 1'b1;
        r.count = pair_count[lo][hi];
        r.sum = pair_sum[lo][hi];
        r.min_w = pair_min[lo][hi];
        r.max_w = pair_max[lo][hi];
      end
      r.unassigned = unassigned_total;
      r.connected = connected_total;
      r.border = border_total;
      expected_results.push_back(r);
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        fails++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      end
    endfunction

    function void check_beat(logic [1:0] kind, logic [215:0] d);
      pair_report_t e;
      if (expected_results.size() == 0) begin
        fails++;
        $display("%0t: unexpected result beat, expected none, actual %0h/%0h",
                 $time, kind, d);
        return;
      end
      e = expected_results.pop_front();
      n_checked++;
      cmp("edge_kind", e.edge_kind, kind);
      cmp("pair_present", e.present, d[0]);
      cmp("pair_edge_count", e.count, d[32:1]);
      cmp("pair_total_weight", e.sum, d[80:33]);
      cmp("pair_min_weight", e.min_w, d[112:81]);
      cmp("pair_max_weight", e.max_w, d[144:113]);
      cmp("unassigned_edge_count", e.unassigned, d[176:145]);
      cmp("connected_pair_count", e.connected, d[183:177]);
      cmp("border_edge_count", e.border, d[215:184]);
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [215:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  region_pair_tracker sb = new();

  region_pair_edge_aggregator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  initial begin
    #RUN_LIMIT;
    $display("Timeout with %0d results outstanding", sb.expected_results.size());
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Input beat first: its report can never leave in the same cycle.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_beat(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[9:5], s_axis_tdata[41:10]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_beat(m_axis_tuser, m_axis_tdata);
  end

  task automatic send_beat(input logic [1:0] mode, input int src, input int tgt,
                           input logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {6'b0, w, tgt[4:0], src[4:0]};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sender holds off until every outstanding report has arrived.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Mostly a few low regions so that pairs repeat and statistics build up.
  function automatic int pick_region();
    int p;
    p = $urandom_range(99);
    if (p < 6) return -1;
    if (p < 50) return $urandom_range(3);
    return $urandom_range(REGIONS - 1);
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_beats(input int n);
    int p;
    logic [1:0] mode;
    repeat (n) begin
      p = $urandom_range(199);
      if (p < 150) mode = MODE_EDGE;
      else if (p < 192) mode = MODE_QUERY;
      else if (p < 195) mode = MODE_CLEAR;
      else if (p < 197) mode = MODE_SPARE;
      else mode = MODE_EDGE;
      send_beat(mode, pick_region(), pick_region(), pick_weight());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 29;
    recv_idle_pct = 69;
    send_beat(MODE_QUERY, 0, 1, '0);           // empty table
    send_beat(MODE_EDGE, 3, 3, 32'h1234);       // same region
    send_beat(MODE_EDGE, -1, -1, 32'h55);       // equal unassigned regions, still same
    send_beat(MODE_EDGE, -1, 5, 32'hAAAA_AAAA); // unassigned
    send_beat(MODE_EDGE, 7, -1, 32'h5555_5555);
    send_beat(MODE_EDGE, 0, 15, '0);            // new pair, lowest weight
    send_beat(MODE_EDGE, 15, 0, '1);            // same pair reversed, top weight
    send_beat(MODE_EDGE, 0, 15, 32'd12345);
    send_beat(MODE_QUERY, 15, 0, '1);
    send_beat(MODE_QUERY, 0, 15, '0);
    send_beat(MODE_QUERY, 4, 4, '0);            // same pair query
    send_beat(MODE_QUERY, -1, 2, '0);           // unassigned query
    send_beat(MODE_QUERY, 1, 2, '0);            // absent pair
    send_beat(MODE_EDGE, 14, 15, 32'h8000_0000);
    send_beat(MODE_EDGE, 2, 1, 32'd7);
    send_beat(MODE_EDGE, 1, 2, 32'd3);
    send_beat(MODE_SPARE, 0, 15, '1);           // reports totals only
    send_beat(MODE_CLEAR, 0, 15, '1);
    send_beat(MODE_QUERY, 0, 15, '0);           // gone after clear
    send_beat(MODE_EDGE, 15, 0, 32'hFFFF_FFFE);
    send_beat(MODE_EDGE, -1, 15, 32'd1);
    send_beat(MODE_QUERY, 0, 15, '0);
    wait_drained();

    random_beats(RANDOM_BEATS / 3);
    wait_drained();
    send_idle_pct = 69;
    recv_idle_pct = 29;
    random_beats(RANDOM_BEATS / 3);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_beats(RANDOM_BEATS - 2 * (RANDOM_BEATS / 3));
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d edge, %0d query and %0d clear beats; %0d reports checked",
             sb.n_edges, sb.n_queries, sb.n_clears, sb.n_checked);
    $display("Final totals: %0d connected pairs, %0d border edges, %0d unassigned edges",
             sb.connected_total, sb.border_total, sb.unassigned_total);
    if (sb.fails == 0 && sb.expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rpea_pkg.sv
rtl/rpea_ctrl.sv
rtl/rpea_datapath.sv
rtl/region_pair_edge_aggregator.sv
test/region_pair_edge_aggregator_test.sv
